// File: design/i2cms_pkg.sv
// shared types, command codes and phase tables for the i2c master bit sequencer
package i2cms_pkg;

	typedef enum logic [2:0] {
		CMD_START = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_ACK   = 3'd4,
		CMD_NACK  = 3'd5
	} cmd_t;

	localparam logic [7:0] HALF_PERIOD_RST = 8'd3;
	localparam logic [4:0] WR_ACK_PHASE    = 5'd25;
	localparam logic [4:0] WR_BITS_END     = 5'd24;

	// one input tick
	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] req_type;
		logic [7:0] wr_data;
		logic       sda_in;
	} item_t;

	// one result tick
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rd_data;
		logic       ack_status;
	} res_t;

	// what a phase does to the pins at its start
	typedef struct packed {
		logic set_scl;
		logic scl;
		logic set_sda;
		logic sda;
	} pin_act_t;

	function automatic logic [4:0] seq_len(cmd_t cmd);
		logic [4:0] n;
		unique case (cmd)
			CMD_START: n = 5'd4;
			CMD_STOP:  n = 5'd3;
			CMD_WRITE: n = 5'd27;
			CMD_READ:  n = 5'd17;
			default:   n = 5'd3;
		endcase
		return n;
	endfunction

	function automatic pin_act_t phase_action(cmd_t cmd, logic [4:0] p, logic [7:0] shift);
		pin_act_t   a;
		logic [8:0] prod;
		logic [2:0] q;
		logic [4:0] r;
		a = '0;
		// p / 3 by reciprocal, exact for the 24 data phases
		prod = {4'b0, p} * 9'd11;
		q = prod[7:5];
		r = p - ({2'b0, q} + {1'b0, q, 1'b0});
		unique case (cmd)
			CMD_START: begin
				if (p == 5'd0) begin
					a.set_sda = 1'b1; a.sda = 1'b1;
				end else if (p == 5'd1) begin
					a.set_scl = 1'b1; a.scl = 1'b1;
				end else if (p == 5'd2) begin
					a.set_sda = 1'b1; a.sda = 1'b0;
				end else begin
					a.set_scl = 1'b1; a.scl = 1'b0;
				end
			end
			CMD_STOP: begin
				if (p == 5'd0) begin
					a.set_sda = 1'b1; a.sda = 1'b0;
				end else if (p == 5'd1) begin
					a.set_scl = 1'b1; a.scl = 1'b1;
				end else begin
					a.set_sda = 1'b1; a.sda = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (p < WR_BITS_END) begin
					if (r == 5'd0) begin
						a.set_sda = 1'b1; a.sda = shift[3'd7 - q];
					end else if (r == 5'd1) begin
						a.set_scl = 1'b1; a.scl = 1'b1;
					end else begin
						a.set_scl = 1'b1; a.scl = 1'b0;
					end
				end else if (p == WR_BITS_END) begin
					a.set_sda = 1'b1; a.sda = 1'b1;
				end else if (p == WR_ACK_PHASE) begin
					a.set_scl = 1'b1; a.scl = 1'b1;
				end else begin
					a.set_scl = 1'b1; a.scl = 1'b0;
				end
			end
			CMD_READ: begin
				if (p == 5'd0) begin
					a.set_sda = 1'b1; a.sda = 1'b1;
				end else begin
					a.set_scl = 1'b1; a.scl = p[0];
				end
			end
			default: begin
				if (p == 5'd0) begin
					a.set_sda = 1'b1; a.sda = (cmd == CMD_NACK);
				end else if (p == 5'd1) begin
					a.set_scl = 1'b1; a.scl = 1'b1;
				end else begin
					a.set_scl = 1'b1; a.scl = 1'b0;
				end
			end
		endcase
		return a;
	endfunction

endpackage

// File: design/i2cms_in_stage.sv
// input register with stall back to the sender
module i2cms_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  i2cms_pkg::item_t item,
	input  logic            adv,
	output logic            valid_s1,
	output i2cms_pkg::item_t item_s1
);

	logic load;

	assign in_stall = valid_s1 & ~adv;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load | (valid_s1 & ~adv);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

// File: design/i2cms_core.sv
// bus sequencer state and the per-tick update
module i2cms_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	input  logic            adv,
	input  i2cms_pkg::item_t item_s1,
	output i2cms_pkg::res_t  res
);

	logic [7:0]      half_period_q;
	logic [4:0]      phase_q,  phase_d;
	logic [7:0]      tick_q,   tick_d;
	logic [7:0]      shift_q,  shift_d;
	i2cms_pkg::cmd_t cmd_q,    cmd_d;
	logic            scl_q,    scl_d;
	logic            sda_q,    sda_d;
	logic            ack_q,    ack_d;
	logic            busy_q,   busy_d;
	logic [7:0]      rd_hold_q, rd_hold_d;
	logic            done_d;

	always_comb begin
		logic [7:0]         tick_inc;
		logic [4:0]         phase_inc;
		logic [7:0]         shift_smp;
		i2cms_pkg::pin_act_t act;
		phase_d   = phase_q;
		tick_d    = tick_q;
		shift_d   = shift_q;
		cmd_d     = cmd_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		ack_d     = ack_q;
		busy_d    = busy_q;
		rd_hold_d = rd_hold_q;
		done_d    = 1'b0;
		tick_inc  = tick_q + 8'd1;
		phase_inc = phase_q + 5'd1;
		shift_smp = shift_q;
		act       = '0;
		if (busy_q) begin
			if (tick_inc >= half_period_q) begin
				// sample at the end of the scl-high phase
				if (cmd_q == i2cms_pkg::CMD_WRITE && phase_q == i2cms_pkg::WR_ACK_PHASE) begin
					ack_d = item_s1.sda_in;
				end else if (cmd_q == i2cms_pkg::CMD_READ && phase_q[0]) begin
					shift_smp = {shift_q[6:0], item_s1.sda_in};
				end
				shift_d = shift_smp;
				tick_d  = 8'd0;
				if (phase_inc >= i2cms_pkg::seq_len(cmd_q)) begin
					busy_d  = 1'b0;
					done_d  = 1'b1;
					phase_d = 5'd0;
					if (cmd_q == i2cms_pkg::CMD_READ) begin
						rd_hold_d = shift_smp;
					end
				end else begin
					phase_d = phase_inc;
					act = i2cms_pkg::phase_action(cmd_q, phase_inc, shift_smp);
				end
			end else begin
				tick_d = tick_inc;
			end
		end else if (item_s1.cmd_valid && item_s1.req_type <= 3'(i2cms_pkg::CMD_NACK)) begin
			cmd_d   = i2cms_pkg::cmd_t'(item_s1.req_type);
			busy_d  = 1'b1;
			phase_d = 5'd0;
			tick_d  = 8'd0;
			shift_d = (cmd_d == i2cms_pkg::CMD_WRITE) ? item_s1.wr_data : 8'd0;
			act = i2cms_pkg::phase_action(cmd_d, 5'd0, shift_d);
		end
		if (act.set_scl) begin
			scl_d = act.scl;
		end
		if (act.set_sda) begin
			sda_d = act.sda;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cms_pkg::HALF_PERIOD_RST;
			phase_q   <= 5'd0;
			tick_q    <= 8'd0;
			shift_q   <= 8'd0;
			cmd_q     <= i2cms_pkg::CMD_START;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			ack_q     <= 1'b0;
			busy_q    <= 1'b0;
			rd_hold_q <= 8'd0;
		end else begin
			if (cfg_we) begin
				half_period_q <= cfg_wdata;
			end
			if (adv) begin
				phase_q   <= phase_d;
				tick_q    <= tick_d;
				shift_q   <= shift_d;
				cmd_q     <= cmd_d;
				scl_q     <= scl_d;
				sda_q     <= sda_d;
				ack_q     <= ack_d;
				busy_q    <= busy_d;
				rd_hold_q <= rd_hold_d;
			end
		end
	end

	assign res.scl_out    = scl_d;
	assign res.sda_out    = sda_d;
	assign res.busy_res   = busy_d;
	assign res.done_res   = done_d;
	assign res.rd_data    = rd_hold_d;
	assign res.ack_status = ack_d;

endmodule

// File: design/i2cms_out_reg.sv
// result register towards the receiver
module i2cms_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  i2cms_pkg::res_t res,
	input  logic           out_stall,
	output logic           out_valid,
	output i2cms_pkg::res_t res_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= adv | (out_valid & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

endmodule

// File: design/i2c_master_bit_sequencer.sv
// i2c master bit sequencer: one bus timing tick per input transaction
//
// Each input transaction on in_valid/in_stall is one tick of bus time. It may
// carry a command (cmd_valid, req_type, wr_data) and always carries the sampled
// sda_in level. Start, stop, write byte, read byte, ack and nack each run as a
// fixed series of phases of half_period ticks; commands that arrive while busy
// are dropped. Every input transaction gives exactly one output transaction on
// out_valid/out_stall holding the scl/sda drive, busy, a done pulse, the last
// read byte and the last write acknowledge.
// From input acceptance a transaction is held in the input register, then the
// update is written into the result register, where the result is offered.
// Throughput is one transaction per cycle while the result side is not stalled.
// A stalled result is held in the result register; an empty input register
// still takes one more transaction, and once it holds one, in_stall is raised until out_stall drops.
// half_period is written through cfg_we/cfg_wdata; the user must write it while idle, the block does not enforce this.
// Reset brings both lines released, the block idle and half_period to 3.
module i2c_master_bit_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd_valid,
	input  logic [2:0] req_type,
	input  logic [7:0] wr_data,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_out,
	output logic       sda_out,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] rd_data,
	output logic       ack_status
);

	i2cms_pkg::item_t item, item_s1;
	i2cms_pkg::res_t  res, res_q;
	logic             valid_s1;
	logic             adv;

	assign item.cmd_valid = cmd_valid;
	assign item.req_type  = req_type;
	assign item.wr_data   = wr_data;
	assign item.sda_in    = sda_in;

	assign adv = valid_s1 & (~out_valid | ~out_stall);

	i2cms_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	i2cms_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.adv       (adv),
		.item_s1   (item_s1),
		.res       (res)
	);

	i2cms_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign scl_out    = res_q.scl_out;
	assign sda_out    = res_q.sda_out;
	assign busy_res   = res_q.busy_res;
	assign done_res   = res_q.done_res;
	assign rd_data    = res_q.rd_data;
	assign ack_status = res_q.ack_status;

endmodule

// File: design/i2cms_checker.sv
// port-level checks for the i2c master bit sequencer, bound to the top level
module i2cms_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl_out,
	input logic       sda_out,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] rd_data,
	input logic       ack_status
);

	// a held result keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid
		&& $stable({scl_out, sda_out, busy_res, done_res, rd_data, ack_status}))
		else $error("stalled result changed");

	// the done tick always leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// input only backs up when the result side is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with result side free");

	// a fresh result follows a transaction accepted through the input register
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching input transaction");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.scl_out    (scl_out),
	.sda_out    (sda_out),
	.busy_res   (busy_res),
	.done_res   (done_res),
	.rd_data    (rd_data),
	.ack_status (ack_status)
);
